### sv/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg - shared types and constants of the shadow call stack tracker
// Default sizes, the fixed block length width and the control word that
// steers every stack cell.
// ----------------------------------------------------------------------------
package sct_pkg;

  // default sizes
  localparam int STACK_DEPTH_DEF   = 64;
  localparam int SEARCH_WINDOW_DEF = 9;
  localparam int ADDRESS_BITS_DEF  = 48;

  // block length field width
  localparam int BLEN_W = 12;

  // shift command shared by all cells of the stack
  typedef struct packed {
    logic push;  // shift toward the bottom, top takes the new frame
    logic pop;   // shift toward the top
  } sct_shift_t;

endpackage

### sv/shadow_call_stack_tracker.sv
// ----------------------------------------------------------------------------
// shadow_call_stack_tracker - shadow call stack over executed code blocks
// Matches each block against the return addresses of the top frames, pops
// to the match, pushes a frame for a call and reports one word per block.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------
//   in      | input     | in_valid, in_stall, block fields
//   out     | output    | out_valid, out_stall, result fields
//
// A block runs through accept, search, one pop per popped frame, a push
// when it ends in a call and a done state that loads the output word. The
// pop count is set by the window search; the cell row moves one slot a cycle.
// Reset clears the frame count, the state and the output valid; frame
// contents are undefined until pushed. A stalled output word is held while
// the next block is accepted and worked; that block waits before loading.
// ----------------------------------------------------------------------------
module shadow_call_stack_tracker
  import sct_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int SEARCH_WINDOW = SEARCH_WINDOW_DEF,
  parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF,
  localparam int CW    = $clog2(STACK_DEPTH + 1),
  localparam int POP_W = $clog2(SEARCH_WINDOW + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // block channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ADDRESS_BITS-1:0] in_block_address,
  input  logic [BLEN_W-1:0]       in_block_length,
  input  logic                    in_ends_in_call,
  input  logic [ADDRESS_BITS-1:0] in_call_target,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_returned,
  output logic [ADDRESS_BITS-1:0] out_returned_function,
  output logic [POP_W-1:0]        out_frames_popped,
  output logic                    out_called,
  output logic [ADDRESS_BITS-1:0] out_called_function,
  output logic                    out_overflowed,
  output logic [CW-1:0]           out_stack_depth,
  output logic [ADDRESS_BITS-1:0] out_top_return_address
);

  localparam int AW  = ADDRESS_BITS;
  localparam int WIN = (SEARCH_WINDOW < STACK_DEPTH) ? SEARCH_WINDOW : STACK_DEPTH;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_POP    = 5'b00100,
    ST_PUSH   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // block held for the run
  logic [AW-1:0]     addr_r;
  logic [BLEN_W-1:0] len_r;
  logic              call_r;
  logic [AW-1:0]     target_r;

  // run state
  logic [CW-1:0]    count_r, count_nxt;
  logic [POP_W-1:0] pop_left_r, pop_left_nxt;
  logic             hit_r, hit_nxt;
  logic [POP_W-1:0] popped_r, popped_nxt;
  logic [AW-1:0]    ret_fn_r, ret_fn_nxt;
  logic             ovf_r, ovf_nxt;

  // output word
  logic             out_valid_r, out_valid_nxt;
  logic             o_ret_r;
  logic [AW-1:0]    o_ret_fn_r;
  logic [POP_W-1:0] o_popped_r;
  logic             o_call_r;
  logic [AW-1:0]    o_call_fn_r;
  logic             o_ovf_r;
  logic [CW-1:0]    o_depth_r;
  logic [AW-1:0]    o_top_r;

  sct_shift_t    shift;
  logic [AW-1:0] cell_ra [STACK_DEPTH];
  logic [AW-1:0] cell_fe [STACK_DEPTH];
  logic [AW-1:0] ra_win  [WIN];
  logic [AW-1:0] fe_win  [WIN];
  logic [AW-1:0] new_ra;
  logic          m_hit;
  logic [POP_W-1:0] m_popped;
  logic [AW-1:0] m_fn;
  logic          accept;
  logic          load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign new_ra   = addr_r + AW'(len_r);

  // row of stack cells, cell 0 is the top frame
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [AW-1:0] up_ra, up_fe, dn_ra, dn_fe;
    if (g == 0) begin : g_top
      assign up_ra = new_ra;
      assign up_fe = target_r;
    end else begin : g_mid
      assign up_ra = cell_ra[g-1];
      assign up_fe = cell_fe[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign dn_ra = cell_ra[g];
      assign dn_fe = cell_fe[g];
    end else begin : g_low
      assign dn_ra = cell_ra[g+1];
      assign dn_fe = cell_fe[g+1];
    end
    sct_cell #(.AW(AW)) u_cell (
      .clk   (clk),
      .shift (shift),
      .up_ra (up_ra),
      .up_fe (up_fe),
      .dn_ra (dn_ra),
      .dn_fe (dn_fe),
      .ra    (cell_ra[g]),
      .fe    (cell_fe[g])
    );
  end

  // search window taps
  for (genvar w = 0; w < WIN; w++) begin : g_win
    assign ra_win[w] = cell_ra[w];
    assign fe_win[w] = cell_fe[w];
  end

  sct_match #(.AW(AW), .WIN(WIN), .CW(CW), .POP_W(POP_W)) u_match (
    .addr   (addr_r),
    .count  (count_r),
    .ra_win (ra_win),
    .fe_win (fe_win),
    .hit    (m_hit),
    .popped (m_popped),
    .fn     (m_fn)
  );

  // sequence one block: search, pop, push, report
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pop_left_nxt = pop_left_r;
    hit_nxt      = hit_r;
    popped_nxt   = popped_r;
    ret_fn_nxt   = ret_fn_r;
    ovf_nxt      = ovf_r;
    shift        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        hit_nxt      = m_hit;
        popped_nxt   = m_popped;
        ret_fn_nxt   = m_fn;
        pop_left_nxt = m_popped;
        ovf_nxt      = 1'b0;
        if (m_hit) begin
          state_nxt = ST_POP;
        end else if (call_r) begin
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP: begin
        shift.pop    = 1'b1;
        count_nxt    = count_r - 1'b1;
        pop_left_nxt = pop_left_r - 1'b1;
        if (pop_left_r == POP_W'(1)) begin
          state_nxt = call_r ? ST_PUSH : ST_DONE;
        end
      end
      ST_PUSH: begin
        shift.push = 1'b1;
        if (count_r == CW'(STACK_DEPTH)) begin
          ovf_nxt = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // run registers
  always_ff @(posedge clk) begin
    pop_left_r <= pop_left_nxt;
    hit_r      <= hit_nxt;
    popped_r   <= popped_nxt;
    ret_fn_r   <= ret_fn_nxt;
    ovf_r      <= ovf_nxt;
    if (accept) begin
      addr_r   <= in_block_address;
      len_r    <= in_block_length;
      call_r   <= in_ends_in_call;
      target_r <= in_call_target;
    end
  end

  // load the output word
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_ret_r     <= hit_r;
      o_ret_fn_r  <= hit_r ? ret_fn_r : '0;
      o_popped_r  <= hit_r ? popped_r : '0;
      o_call_r    <= call_r;
      o_call_fn_r <= call_r ? target_r : '0;
      o_ovf_r     <= call_r && ovf_r;
      o_depth_r   <= count_r;
      o_top_r     <= (count_r != '0) ? cell_ra[0] : '0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_returned           = o_ret_r;
  assign out_returned_function  = o_ret_fn_r;
  assign out_frames_popped      = o_popped_r;
  assign out_called             = o_call_r;
  assign out_called_function    = o_call_fn_r;
  assign out_overflowed         = o_ovf_r;
  assign out_stack_depth        = o_depth_r;
  assign out_top_return_address = o_top_r;

  // frame count never passes the stack size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("frame count above stack size");

  // a pop cycle always has frames left to pop
  a_pop_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> (pop_left_r != '0) && (count_r != '0))
    else $error("pop with nothing left");

  // overflow only on a push that leaves the stack full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_ovf_r) |-> o_call_r && (o_depth_r == CW'(STACK_DEPTH)))
    else $error("overflow without full push");

  // a pushed frame shows up as the top return address
  a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |=> (cell_ra[0] == $past(new_ra)))
    else $error("pushed frame not at top");

endmodule

### sv/sct_cell.sv
// ----------------------------------------------------------------------------
// sct_cell - one frame slot of the shadow stack
// Holds a return address and a function entry; on push it takes the frame
// of its upper neighbor, on pop the frame of its lower neighbor.
// ----------------------------------------------------------------------------
module sct_cell
  import sct_pkg::*;
#(
  parameter int AW = ADDRESS_BITS_DEF
) (
  input  logic          clk,
  input  sct_shift_t    shift,
  input  logic [AW-1:0] up_ra,
  input  logic [AW-1:0] up_fe,
  input  logic [AW-1:0] dn_ra,
  input  logic [AW-1:0] dn_fe,
  output logic [AW-1:0] ra,
  output logic [AW-1:0] fe
);

  logic [AW-1:0] ra_r, ra_nxt;
  logic [AW-1:0] fe_r, fe_nxt;

  // pick the neighbor to take from
  always_comb begin
    ra_nxt = ra_r;
    fe_nxt = fe_r;
    if (shift.push) begin
      ra_nxt = up_ra;
      fe_nxt = up_fe;
    end else if (shift.pop) begin
      ra_nxt = dn_ra;
      fe_nxt = dn_fe;
    end
  end

  // hold the frame
  always_ff @(posedge clk) begin
    ra_r <= ra_nxt;
    fe_r <= fe_nxt;
  end

  assign ra = ra_r;
  assign fe = fe_r;

endmodule

### sv/sct_match.sv
// ----------------------------------------------------------------------------
// sct_match - return address search over the topmost frames
// Compares the block address with each held frame of the window and picks
// the match closest to the top.
// ----------------------------------------------------------------------------
module sct_match
  import sct_pkg::*;
#(
  parameter int AW    = ADDRESS_BITS_DEF,
  parameter int WIN   = SEARCH_WINDOW_DEF,
  parameter int CW    = 7,
  parameter int POP_W = 4
) (
  input  logic [AW-1:0]    addr,
  input  logic [CW-1:0]    count,
  input  logic [AW-1:0]    ra_win [WIN],
  input  logic [AW-1:0]    fe_win [WIN],
  output logic             hit,
  output logic [POP_W-1:0] popped,
  output logic [AW-1:0]    fn
);

  logic [WIN-1:0] match;

  // compare every held frame of the window
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      match[i] = (count > CW'(i)) && (ra_win[i] == addr);
    end
  end

  // take the match nearest the top
  always_comb begin
    hit    = 1'b0;
    popped = '0;
    fn     = '0;
    for (int i = WIN - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit    = 1'b1;
        popped = POP_W'(i + 1);
        fn     = fe_win[i];
      end
    end
  end

endmodule
